>>> src/lfpd_pkg.sv
// Shared types and constants for the length-framed packet deframer.
// No dependencies.
package lfpd_pkg;

  // Result status codes carried on frame_status
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_END   = 2'd1,
    STATUS_SHORT     = 2'd2
  } status_t;

  // Configuration register indexes (byte address is 4 * index)
  localparam int unsigned REG_START_MARKER = 0;
  localparam int unsigned REG_END_MARKER   = 1;

  // Marker values after reset
  localparam logic [7:0] START_MARKER_RESET = 8'hAA;
  localparam logic [7:0] END_MARKER_RESET   = 8'h55;

  // Number of held button bytes reported on each result
  localparam int unsigned HELD_FIELDS = 3;

endpackage

>>> src/length_framed_packet_deframer.sv
// Top level of the length-framed packet deframer: frame parser, APB register port
// and registered result stage. Depends on lfpd_pkg.

// Byte-stream deframer. Each beat on the input channel carries one received
// byte; the block hunts for the start marker, reads a length byte, takes that
// many payload bytes (keeping the first CAPTURE_BYTES) and then a trailer byte,
// at which it emits one result beat with the frame status, the held button
// bytes and the frame length. The phase update is done between the input port
// and the result register, so a new byte is accepted every cycle while the
// result register is empty or being drained in the same cycle. Marker registers
// sit at byte addresses 0 (start) and 4 (end); the user must write them only
// while no frame byte is in flight, as the block itself does not enforce this.
module length_framed_packet_deframer
  import lfpd_pkg::*;
#(
  parameter int unsigned CAPTURE_BYTES = 3
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  frame_status,
  output logic [7:0]  held_byte0,
  output logic [7:0]  held_byte1,
  output logic [7:0]  held_byte2,
  output logic [7:0]  frame_length
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  phase_t     phase;
  logic [7:0] bytes_left;
  logic [7:0] length_seen;
  logic [7:0] capture [CAPTURE_BYTES];
  logic [7:0] held    [CAPTURE_BYTES];
  logic [7:0] held_next [CAPTURE_BYTES];
  logic [7:0] held_fields [HELD_FIELDS];
  logic [7:0] start_marker;
  logic [7:0] end_marker;

  logic       in_fire;
  logic       trailer;
  logic       frame_ok;
  logic [7:0] pos;
  status_t    status_next;
  logic       cfg_write;
  logic       reg_sel;

  // Result register is free when empty or draining this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign trailer  = in_fire && (phase == PH_END);
  assign pos      = length_seen - bytes_left;

  // Classify the trailer: bad end byte takes priority over short payload
  always_comb begin
    if (rx_byte != end_marker) begin
      status_next = STATUS_BAD_END;
    end else if (length_seen < 8'(CAPTURE_BYTES)) begin
      status_next = STATUS_SHORT;
    end else begin
      status_next = STATUS_OK;
    end
  end
  assign frame_ok = trailer && (status_next == STATUS_OK);

  // Held state after this beat, and the fields reported on the result
  genvar k;
  generate
    for (k = 0; k < CAPTURE_BYTES; k++) begin : g_held
      assign held_next[k] = frame_ok ? capture[k] : held[k];
    end
    for (k = 0; k < HELD_FIELDS; k++) begin : g_field
      if (k < CAPTURE_BYTES) begin : g_used
        assign held_fields[k] = held_next[k];
      end else begin : g_zero
        assign held_fields[k] = 8'd0;
      end
    end
  endgenerate

  // Frame parser: phase, counters and captured payload bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      bytes_left  <= 8'd0;
      length_seen <= 8'd0;
      for (int i = 0; i < CAPTURE_BYTES; i++) begin
        capture[i] <= 8'd0;
        held[i]    <= 8'd0;
      end
    end else if (in_fire) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == start_marker) begin
            phase <= PH_LEN;
          end
        end
        PH_LEN: begin
          length_seen <= rx_byte;
          bytes_left  <= rx_byte;
          phase       <= (rx_byte == 8'd0) ? PH_END : PH_DATA;
        end
        PH_DATA: begin
          for (int i = 0; i < CAPTURE_BYTES; i++) begin
            if (pos == 8'(i)) begin
              capture[i] <= rx_byte;
            end
          end
          bytes_left <= bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase <= PH_END;
          end
        end
        default: begin
          for (int i = 0; i < CAPTURE_BYTES; i++) begin
            held[i] <= held_next[i];
          end
          phase      <= PH_HUNT;
          bytes_left <= 8'd0;
        end
      endcase
    end
  end

  // Result register: load on trailer, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (trailer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (trailer) begin
      frame_status <= status_next;
      held_byte0   <= held_fields[0];
      held_byte1   <= held_fields[1];
      held_byte2   <= held_fields[2];
      frame_length <= length_seen;
    end
  end

  // APB register port: word index from paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      end_marker   <= END_MARKER_RESET;
    end else if (cfg_write) begin
      if (reg_sel == 1'(REG_START_MARKER)) begin
        start_marker <= pwdata[7:0];
      end else begin
        end_marker <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == 1'(REG_END_MARKER)) begin
      prdata = {24'd0, end_marker};
    end else begin
      prdata = {24'd0, start_marker};
    end
  end

  // Payload phase always has bytes still to come
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != 8'd0)
    else $error("data phase with zero bytes left");

  // A trailer beat always produces a result on the next cycle
  a_trailer_result: assert property (@(posedge clk) disable iff (rst)
    trailer |=> out_valid && phase == PH_HUNT)
    else $error("trailer did not load a result");

  // An ok result only comes from a long enough payload
  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == STATUS_OK |-> frame_length >= 8'(CAPTURE_BYTES))
    else $error("ok status on short payload");

  // Input is never stalled while the result register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Held state changes only on an ok trailer
  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !frame_ok |=> held[0] == $past(held[0]))
    else $error("held state changed without ok frame");

endmodule

>>> bench/tb.sv
// Self-checking testbench for length_framed_packet_deframer: directed frames, then
// random framed byte streams under several marker settings with random idling.
// Depends on lfpd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb
  import lfpd_pkg::*;
();

  localparam int CAPTURE = 3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 310;
  localparam int NUM_PHASES = 5;
  localparam int DIRECTED_ROWS = 23;

  typedef enum logic [1:0] {
    P_HUNT    = 2'd0,
    P_LENGTH  = 2'd1,
    P_PAYLOAD = 2'd2,
    P_TRAILER = 2'd3
  } parse_phase_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] held0;
    logic [7:0] held1;
    logic [7:0] held2;
    logic [7:0] length;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  localparam frame_result_t NO_RESULT = '{STATUS_OK, 8'h00, 8'h00, 8'h00, 8'h00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  frame_status;
  logic [7:0]  held_byte0;
  logic [7:0]  held_byte1;
  logic [7:0]  held_byte2;
  logic [7:0]  frame_length;

  // Predictor state
  logic [7:0]   p_start = START_MARKER_RESET;
  logic [7:0]   p_end = END_MARKER_RESET;
  parse_phase_t p_phase = P_HUNT;
  logic [7:0]   p_left = '0;
  logic [7:0]   p_len = '0;
  logic [7:0]   p_capture [CAPTURE] = '{default: 8'h00};
  logic [7:0]   p_held [CAPTURE] = '{default: 8'h00};

  frame_result_t pending_frames[$];
  stim_row_t     directed_rows [DIRECTED_ROWS];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            send_count = 0;
  int            send_gap_pct = 0;
  int            recv_stall_pct = 0;
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;

  length_framed_packet_deframer #(.CAPTURE_BYTES(CAPTURE)) u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_status(frame_status),
    .held_byte0  (held_byte0),
    .held_byte1  (held_byte1),
    .held_byte2  (held_byte2),
    .frame_length(frame_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Advance the frame parser by one byte; return 1 when the byte closes a frame
  function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
    logic [7:0] pos;
    r = NO_RESULT;
    deframe_byte = 1'b0;
    case (p_phase)
      P_HUNT: begin
        if (b == p_start) p_phase = P_LENGTH;
      end
      P_LENGTH: begin
        p_len = b;
        p_left = b;
        p_phase = (b == 8'd0) ? P_TRAILER : P_PAYLOAD;
      end
      P_PAYLOAD: begin
        pos = p_len - p_left;
        if (pos < CAPTURE) p_capture[pos] = b;
        p_left = p_left - 8'd1;
        if (p_left == 8'd0) p_phase = P_TRAILER;
      end
      default: begin
        if (b != p_end) begin
          r.status = STATUS_BAD_END;
        end else if (p_len < CAPTURE) begin
          r.status = STATUS_SHORT;
        end else begin
          r.status = STATUS_OK;
          for (int k = 0; k < CAPTURE; k++) p_held[k] = p_capture[k];
        end
        p_phase = P_HUNT;
        p_left = 8'd0;
        r.held0 = p_held[0];
        r.held1 = p_held[1];
        r.held2 = p_held[2];
        r.length = p_len;
        deframe_byte = 1'b1;
      end
    endcase
  endfunction

  // Offer one byte, hold it until accepted, then queue what it produces
  task automatic send_byte(input logic [7:0] b, input bit use_typed = 1'b0,
                           input frame_result_t typed_want = NO_RESULT);
    frame_result_t r;
    bit            has;
    send_count++;
    if (send_count % 40 == 0) send_gap_pct = 8 * $urandom_range(0, 3);
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = deframe_byte(b, r);
    if (use_typed) pending_frames = {pending_frames, typed_want};
    else if (has) pending_frames = {pending_frames, r};
  endtask

  // Write a marker register over APB, read it back, and track it in the predictor
  task automatic write_marker(input int unsigned idx, input logic [7:0] value);
    logic [7:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata[7:0];
    psel <= 1'b0;
    penable <= 1'b0;
    if (got != value) begin
      $error("marker register %0d: expected %0h, actual %0h", idx, value, got);
      mismatch_count++;
    end
    if (idx == REG_START_MARKER) p_start = value;
    else p_end = value;
  endtask

  // Drain the result channel and let any trailing byte work finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, some noise and bad trailers
  task automatic random_frames(input int budget, input bit with_hold);
    int         counted;
    int         len;
    int         pick;
    bit         hold_done;
    logic [7:0] trailer;
    counted = 0;
    hold_done = 1'b0;
    while (counted < budget) begin
      if (with_hold && !hold_done && counted >= 100) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(0, 6);
      else if (pick < 98) len = $urandom_range(7, 40);
      else if (pick == 98) len = 255;
      else len = $urandom_range(128, 254);
      send_byte(p_start);
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      trailer = ($urandom_range(0, 99) < 85) ? p_end : 8'($urandom_range(0, 255));
      send_byte(trailer);
      counted += len + 3;
    end
    // close any frame that a noise byte opened
    while (p_phase != P_HUNT) send_byte(p_end);
  endtask

  // Result channel: random stall bursts, one long hold-off on request
  initial begin
    int rounds;
    rounds = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      rounds++;
      if (rounds % 64 == 0) recv_stall_pct = 5 * $urandom_range(0, 3);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < recv_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each result beat with the oldest expected frame
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result beat: status %0d length %0d", frame_status, frame_length);
        mismatch_count++;
      end else begin
        want = pending_frames.pop_front();
        if (frame_status != want.status) begin
          $error("frame_status: expected %0d, actual %0d", want.status, frame_status);
          mismatch_count++;
        end
        if (held_byte0 != want.held0) begin
          $error("held_byte0: expected %0h, actual %0h", want.held0, held_byte0);
          mismatch_count++;
        end
        if (held_byte1 != want.held1) begin
          $error("held_byte1: expected %0h, actual %0h", want.held1, held_byte1);
          mismatch_count++;
        end
        if (held_byte2 != want.held2) begin
          $error("held_byte2: expected %0h, actual %0h", want.held2, held_byte2);
          mismatch_count++;
        end
        if (frame_length != want.length) begin
          $error("frame_length: expected %0d, actual %0d", want.length, frame_length);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    logic [7:0] start_val;
    logic [7:0] end_val;
    directed_rows = '{
      '{8'h00, 1'b0, NO_RESULT},
      // good frame, three payload bytes
      '{8'hAA, 1'b0, NO_RESULT}, '{8'h03, 1'b0, NO_RESULT},
      '{8'h11, 1'b0, NO_RESULT}, '{8'h22, 1'b0, NO_RESULT}, '{8'h33, 1'b0, NO_RESULT},
      '{8'h55, 1'b1, '{STATUS_OK, 8'h11, 8'h22, 8'h33, 8'd3}},
      // zero length: next byte is the trailer, payload too short
      '{8'hAA, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
      '{8'h55, 1'b1, '{STATUS_SHORT, 8'h11, 8'h22, 8'h33, 8'd0}},
      // long payload: extra bytes skipped
      '{8'hAA, 1'b0, NO_RESULT}, '{8'h05, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT}, '{8'hFE, 1'b0, NO_RESULT}, '{8'hFD, 1'b0, NO_RESULT},
      '{8'hFC, 1'b0, NO_RESULT}, '{8'hFB, 1'b0, NO_RESULT},
      '{8'h55, 1'b1, '{STATUS_OK, 8'hFF, 8'hFE, 8'hFD, 8'd5}},
      // bad trailer wins over short payload; trailer equal to start is consumed
      '{8'hAA, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
      '{8'hAA, 1'b1, '{STATUS_BAD_END, 8'hFF, 8'hFE, 8'hFD, 8'd0}},
      '{8'h03, 1'b0, NO_RESULT}, '{8'h55, 1'b0, NO_RESULT}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: begin start_val = 8'h00; end_val = 8'hFF; end
          2: begin start_val = 8'hFF; end_val = 8'h00; end
          3: begin
            start_val = 8'($urandom_range(0, 255));
            end_val = 8'($urandom_range(0, 255));
          end
          default: begin start_val = 8'h5A; end_val = 8'h5A; end
        endcase
        write_marker(REG_START_MARKER, start_val);
        write_marker(REG_END_MARKER, end_val);
      end
      calm = (ph == NUM_PHASES - 1);
      random_frames(PHASE_ITEMS, ph == 0);
    end

    // Drain and report
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
